>>> sv/tql_pkg.sv
// shared types and constants for the line-world q-learning agent
// no dependencies; imported by tql_ctrl, tql_datapath and the top level
package tql_pkg;

    localparam int LINE_POSITIONS = 7;
    localparam int POS_W = 3;
    localparam int CFG_IDX_W = 3;

    localparam logic [POS_W-1:0] GOAL_POS = POS_W'(LINE_POSITIONS - 1);

    localparam logic signed [25:0] REWARD_GOAL = 26'sd16777216;
    localparam logic signed [25:0] REWARD_STEP = -26'sd167772;

    localparam logic [15:0] LEARN_RATE_RST = 16'd13107;
    localparam logic [15:0] DISCOUNT_RST = 16'd64225;
    localparam logic [15:0] EXPLORE_RATE_RST = 16'd13107;
    localparam logic [63:0] SEED_RST = 64'd1234;
    localparam logic [7:0] STEP_LIMIT_RST = 8'd30;

    typedef enum logic [1:0] {
        OP_STEP = 2'd0,
        OP_READ = 2'd1,
        OP_WRITE = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEARN_RATE = 3'd0,
        CFG_DISCOUNT = 3'd1,
        CFG_EXPLORE_RATE = 3'd2,
        CFG_SEED_VALUE = 3'd3,
        CFG_EVAL_ONLY = 3'd4,
        CFG_STEP_LIMIT = 3'd5
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROW,
        ST_NEXT,
        ST_MUL,
        ST_WB
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic choose;
        logic best;
        logic update;
        logic commit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_step;
    } stat_t;

endpackage

>>> sv/tabular_q_learning_line_agent_top.sv
// one word at a time: the sequencer walks a step through row read, next-row read, two
// registered multiplies and write-back, and a read/write through row read and write-back
// only, before the next start is taken
// the next word may be accepted in the same cycle its predecessor's result is shown
// results are a one-cycle strobe; the receiver cannot stall
// reset: table reads zero via per-entry valid bits, generator loads 1234, no clearing pass
module tabular_q_learning_line_agent_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           cfg_we,
    input  logic [tql_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [63:0]                    cfg_data,
    input  logic [1:0]                     op,
    input  logic [2:0]                     entry_pos,
    input  logic                           entry_action,
    input  logic signed [31:0]             entry_value,
    output logic                           result_valid,
    output logic                           chosen_action,
    output logic                           explored,
    output logic signed [25:0]             reward,
    output logic [2:0]                     new_pos,
    output logic                           episode_done,
    output logic signed [31:0]             episode_return,
    output logic signed [31:0]             q_value
);
    import tql_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    tql_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    tql_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .op             (op),
        .entry_pos      (entry_pos),
        .entry_action   (entry_action),
        .entry_value    (entry_value),
        .result_valid   (result_valid),
        .chosen_action  (chosen_action),
        .explored       (explored),
        .reward         (reward),
        .new_pos        (new_pos),
        .episode_done   (episode_done),
        .episode_return (episode_return),
        .q_value        (q_value)
    );

endmodule

>>> sv/tql_ctrl.sv
// sequencer for the agent: accepts a word and steps the datapath through its phases
// depends on tql_pkg
module tql_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  tql_pkg::stat_t stat,
    output tql_pkg::cmd_t  cmd,
    output logic           busy
);
    import tql_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        busy = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_ROW;
                end
            end
            ST_ROW:
            begin
                // table access words skip the update arithmetic
                if (stat.is_step)
                begin
                    cmd.choose = 1'b1;
                    state_next = ST_NEXT;
                end
                else
                begin
                    state_next = ST_WB;
                end
            end
            ST_NEXT:
            begin
                cmd.best = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.update = 1'b1;
                state_next = ST_WB;
            end
            ST_WB:
            begin
                cmd.commit = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> sv/tql_datapath.sv
// q table, generator, agent state, config registers and update arithmetic
// depends on tql_pkg; sequenced by tql_ctrl through cmd_t
module tql_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  tql_pkg::cmd_t                  cmd,
    output tql_pkg::stat_t                 stat,
    input  logic                           cfg_we,
    input  logic [tql_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [63:0]                    cfg_data,
    input  logic [1:0]                     op,
    input  logic [2:0]                     entry_pos,
    input  logic                           entry_action,
    input  logic signed [31:0]             entry_value,
    output logic                           result_valid,
    output logic                           chosen_action,
    output logic                           explored,
    output logic signed [25:0]             reward,
    output logic [2:0]                     new_pos,
    output logic                           episode_done,
    output logic signed [31:0]             episode_return,
    output logic signed [31:0]             q_value
);
    import tql_pkg::*;

    function automatic logic [63:0] xs64(input logic [63:0] v);
        logic [63:0] x;
        x = v;
        x = x ^ (x << 13);
        x = x ^ (x >> 7);
        x = x ^ (x << 17);
        return x;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
        logic signed [31:0] r;
        if (v[36:31] == {6{v[36]}})
        begin
            r = v[31:0];
        end
        else if (v[36])
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = 32'sh7fff_ffff;
        end
        return r;
    endfunction

    // config
    logic [15:0] learn_rate_reg;
    logic [15:0] discount_reg;
    logic [15:0] explore_rate_reg;
    logic        eval_only_reg;
    logic [7:0]  step_limit_reg;

    // agent state
    logic [63:0]        rng_reg;
    logic [63:0]        rng_adv;
    logic [POS_W-1:0]   pos_reg;
    logic [7:0]         cnt_reg;
    logic signed [31:0] ret_reg;

    // table memory, one array per action, valid bits stand for the zero reset
    logic signed [31:0] mem_l [LINE_POSITIONS];
    logic signed [31:0] mem_r [LINE_POSITIONS];
    logic [LINE_POSITIONS-1:0] vld_l_reg;
    logic [LINE_POSITIONS-1:0] vld_r_reg;
    logic signed [31:0] rd_l_reg;
    logic signed [31:0] rd_r_reg;
    logic               rd_en;
    logic               rd_ok;
    logic [POS_W-1:0]   rd_addr;
    logic               wr_en;
    logic [POS_W-1:0]   wr_pos;
    logic               wr_act;
    logic signed [31:0] wr_data;

    // latched word
    logic [1:0]         op_reg;
    logic [POS_W-1:0]   epos_reg;
    logic               eact_reg;
    logic signed [31:0] evalue_reg;
    logic               erange_reg;

    // step working registers
    logic [POS_W-1:0]   idx_pos_reg;
    logic               act_reg;
    logic               expl_reg;
    logic signed [31:0] cur_reg;
    logic               done_reg;
    logic signed [25:0] rew_reg;
    logic signed [48:0] prod1_reg;
    logic signed [51:0] prod2_reg;

    // result registers
    logic               valid_reg;
    logic               out_act_reg;
    logic               out_expl_reg;
    logic signed [25:0] out_rew_reg;
    logic [2:0]         out_pos_reg;
    logic               out_done_reg;
    logic signed [31:0] out_ret_reg;
    logic signed [31:0] out_q_reg;

    // choose phase
    logic [63:0]        x1;
    logic [63:0]        x2;
    logic               explore;
    logic               action;
    logic [POS_W-1:0]   npos;
    logic [7:0]         cnt_inc;
    logic               reached;

    // update phase
    logic signed [31:0] best;
    logic signed [48:0] prod1_next;
    logic signed [32:0] disc_term;
    logic signed [33:0] target;
    logic signed [34:0] diff;
    logic signed [51:0] prod2_next;
    logic signed [36:0] q_sum;
    logic signed [31:0] q_new;
    logic signed [36:0] ret_sum;
    logic signed [31:0] ret_new;

    assign stat.is_step = (op_reg == OP_STEP);

    always_comb
    begin
        x1 = xs64(rng_reg);
        x2 = xs64(x1);
        explore = !eval_only_reg && (x1[63:11] < {explore_rate_reg, 37'd0});
        action = explore ? x2[63] : (rd_r_reg > rd_l_reg);
        npos = pos_reg;
        if (!action && pos_reg != '0)
        begin
            npos = pos_reg - POS_W'(1);
        end
        else if (action && pos_reg != GOAL_POS)
        begin
            npos = pos_reg + POS_W'(1);
        end
        cnt_inc = (cnt_reg == 8'hff) ? cnt_reg : cnt_reg + 8'd1;
        reached = (npos == GOAL_POS);
        rng_adv = explore ? x2 : x1;

        best = (rd_r_reg > rd_l_reg) ? rd_r_reg : rd_l_reg;
        prod1_next = $signed({1'b0, discount_reg}) * best;

        // floor by 2^16 is the arithmetic upper slice
        disc_term = done_reg ? 33'sd0 : prod1_reg[48:16];
        target = {{8{rew_reg[25]}}, rew_reg} + {disc_term[32], disc_term};
        diff = {target[33], target} - {{3{cur_reg[31]}}, cur_reg};
        prod2_next = $signed({1'b0, learn_rate_reg}) * diff;

        q_sum = {prod2_reg[51], prod2_reg[51:16]} + {{5{cur_reg[31]}}, cur_reg};
        q_new = sat32(q_sum);
        ret_sum = {{5{ret_reg[31]}}, ret_reg} + {{11{rew_reg[25]}}, rew_reg};
        ret_new = sat32(ret_sum);
    end

    // table port control
    always_comb
    begin
        rd_en = cmd.load || cmd.choose;
        rd_ok = 1'b1;
        rd_addr = npos;
        if (cmd.load)
        begin
            if (op == OP_STEP)
            begin
                rd_addr = pos_reg;
            end
            else
            begin
                rd_addr = entry_pos;
                rd_ok = (entry_pos < POS_W'(LINE_POSITIONS));
            end
        end

        wr_en = 1'b0;
        wr_pos = idx_pos_reg;
        wr_act = act_reg;
        wr_data = q_new;
        if (cmd.commit)
        begin
            if (op_reg == OP_STEP)
            begin
                wr_en = !eval_only_reg;
            end
            else if (op_reg == OP_WRITE)
            begin
                wr_en = erange_reg;
                wr_pos = epos_reg;
                wr_act = eact_reg;
                wr_data = evalue_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && !wr_act)
        begin
            mem_l[wr_pos] <= wr_data;
        end
        if (wr_en && wr_act)
        begin
            mem_r[wr_pos] <= wr_data;
        end
        if (rd_en)
        begin
            rd_l_reg <= (rd_ok && vld_l_reg[rd_addr]) ? mem_l[rd_addr] : '0;
            rd_r_reg <= (rd_ok && vld_r_reg[rd_addr]) ? mem_r[rd_addr] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_l_reg <= '0;
            vld_r_reg <= '0;
        end
        else if (wr_en)
        begin
            if (wr_act)
            begin
                vld_r_reg[wr_pos] <= 1'b1;
            end
            else
            begin
                vld_l_reg[wr_pos] <= 1'b1;
            end
        end
    end

    // config, generator and agent state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            learn_rate_reg <= LEARN_RATE_RST;
            discount_reg <= DISCOUNT_RST;
            explore_rate_reg <= EXPLORE_RATE_RST;
            eval_only_reg <= 1'b0;
            step_limit_reg <= STEP_LIMIT_RST;
            rng_reg <= SEED_RST;
            pos_reg <= '0;
            cnt_reg <= '0;
            ret_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= cmd.commit;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_LEARN_RATE:   learn_rate_reg <= cfg_data[15:0];
                    CFG_DISCOUNT:     discount_reg <= cfg_data[15:0];
                    CFG_EXPLORE_RATE: explore_rate_reg <= cfg_data[15:0];
                    CFG_SEED_VALUE:   rng_reg <= cfg_data;
                    CFG_EVAL_ONLY:    eval_only_reg <= cfg_data[0];
                    CFG_STEP_LIMIT:   step_limit_reg <= cfg_data[7:0];
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.choose)
            begin
                if (!eval_only_reg)
                begin
                    rng_reg <= rng_adv;
                end
                pos_reg <= npos;
                cnt_reg <= cnt_inc;
            end
            if (cmd.commit && op_reg == OP_STEP)
            begin
                if (done_reg)
                begin
                    pos_reg <= '0;
                    cnt_reg <= '0;
                    ret_reg <= '0;
                end
                else
                begin
                    ret_reg <= ret_new;
                end
            end
        end
    end

    // working and result words
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= op;
            epos_reg <= entry_pos;
            eact_reg <= entry_action;
            evalue_reg <= entry_value;
            erange_reg <= (entry_pos < POS_W'(LINE_POSITIONS));
            idx_pos_reg <= pos_reg;
        end
        if (cmd.choose)
        begin
            act_reg <= action;
            expl_reg <= explore;
            cur_reg <= action ? rd_r_reg : rd_l_reg;
            done_reg <= reached || (cnt_inc >= step_limit_reg);
            rew_reg <= reached ? REWARD_GOAL : REWARD_STEP;
        end
        if (cmd.best)
        begin
            prod1_reg <= prod1_next;
        end
        if (cmd.update)
        begin
            prod2_reg <= prod2_next;
        end
        if (cmd.commit)
        begin
            out_pos_reg <= pos_reg;
            if (op_reg == OP_STEP)
            begin
                out_act_reg <= act_reg;
                out_expl_reg <= expl_reg;
                out_rew_reg <= rew_reg;
                out_done_reg <= done_reg;
                out_ret_reg <= ret_new;
                out_q_reg <= eval_only_reg ? cur_reg : q_new;
            end
            else
            begin
                out_act_reg <= 1'b0;
                out_expl_reg <= 1'b0;
                out_rew_reg <= '0;
                out_done_reg <= 1'b0;
                out_ret_reg <= ret_reg;
                case (op_reg)
                    OP_READ:  out_q_reg <= erange_reg ? (eact_reg ? rd_r_reg : rd_l_reg) : '0;
                    OP_WRITE: out_q_reg <= erange_reg ? evalue_reg : '0;
                    default:  out_q_reg <= '0;
                endcase
            end
        end
    end

    assign result_valid = valid_reg;
    assign chosen_action = out_act_reg;
    assign explored = out_expl_reg;
    assign reward = out_rew_reg;
    assign new_pos = out_pos_reg;
    assign episode_done = out_done_reg;
    assign episode_return = out_ret_reg;
    assign q_value = out_q_reg;

endmodule
